/* sv/pihr_pkg.sv */
package pihr_pkg;

    localparam int unsigned BPM_W      = 8;
    localparam int unsigned IVL_W      = 11;
    localparam int unsigned TICK_W     = 12;
    localparam int unsigned WIN_W      = 5;
    localparam int unsigned AGREE_W    = 5;
    localparam int unsigned HOLD_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AGREE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HOLD   = 3'd4;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_BEAT = 1'b1;

    localparam logic [15:0]      BPM_DIVIDEND = 16'd60000;
    localparam logic [BPM_W-1:0] SEED_MIN     = 8'd40;
    localparam logic [BPM_W-1:0] BPM_SAT      = 8'd255;
    localparam logic [9:0]       SLOW_BIAS    = 10'd700;
    localparam logic [3:0]       SLOW_DIV     = 4'd11;

    // Division by eleven as a multiply by 745 and a shift by 13; exact for
    // every dividend below 2730, which covers 700 plus any byte.
    localparam logic [9:0]       SLOW_RECIP   = 10'd745;
    localparam int unsigned      SLOW_SHIFT   = 13;

    // Request from the sequencer to the divider, and its reply.
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

/* sv/pihr_ram.sv */
module pihr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/pihr_div.sv */
module pihr_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pihr_pkg::div_req_t      req,
    output pihr_pkg::div_rsp_t      rsp
);

    import pihr_pkg::*;

    // Restoring division, one quotient bit a cycle.
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[15]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[16])
            begin
                rem_next = {rem_reg[14:0], quo_reg[15]};
                quo_next = {quo_reg[14:0], 1'b0};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* sv/pulse_interval_heart_rate.sv */
// Two-channel heart rate block for a chest strap and a hand grip. Each input item is
// either a one millisecond tick, which applies to both channels, or a beat pulse on one
// channel; every item gives exactly one result item holding the chosen rate, the blink
// indicator and both channel rates. A tick, or a beat that only arms its channel or
// comes too soon, passes from acceptance through the result state into the output
// register. A beat that enters the history takes a longer path: the histories live
// in one synchronous RAM with a registered read, the shift reads and then writes each
// entry in turn, the cluster search reads every entry once for each seed of at least
// 40, and the bpm conversion and the cluster mean each use a shared sixteen-bit serial
// divider. After reset a clearing pass writes zeros through the whole history RAM, one
// RAM word per cycle (all 64 words at the default depth), during which no item is
// accepted; configuration writes are taken at any time. One item is processed at a
// time, and the next is accepted once the previous result item has been taken from the
// output register.
module pulse_interval_heart_rate #(
    parameter int unsigned HISTORY_DEPTH = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic                             channel,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pihr_pkg::BPM_W-1:0]       heart_rate,
    output logic                             beat_blink,
    output logic                             rate_source,
    output logic [pihr_pkg::BPM_W-1:0]       chest_bpm,
    output logic [pihr_pkg::BPM_W-1:0]       hand_bpm,
    input  logic                             cfg_we,
    input  logic [pihr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pihr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import pihr_pkg::*;

    // Entries per channel, and address of one entry: channel bit above the index.
    localparam int unsigned IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int unsigned ADDR_W = IDX_W + 1;
    localparam int unsigned RAM_D  = 2 ** ADDR_W;
    localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SUM_W  = CNT_W + BPM_W;
    localparam int unsigned CMP_W  = CNT_W + AGREE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_DIVBPM = 14'b00000000000100,
        ST_SHRD   = 14'b00000000001000,
        ST_SHWR   = 14'b00000000010000,
        ST_HEAD   = 14'b00000000100000,
        ST_SEEDRD = 14'b00000001000000,
        ST_SEED   = 14'b00000010000000,
        ST_SCAN   = 14'b00000100000000,
        ST_MEAN   = 14'b00001000000000,
        ST_DECIDE = 14'b00010000000000,
        ST_SLOW   = 14'b00100000000000,
        ST_RESULT = 14'b01000000000000,
        ST_HOLD   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [IVL_W-1:0]   min_ivl_reg, max_ivl_reg;
    logic [WIN_W-1:0]   window_reg;
    logic [AGREE_W-1:0] agree_reg;
    logic [HOLD_W-1:0]  hold_reg;

    // Per-channel scalar state, index 0 chest and 1 hand.
    logic [TICK_W-1:0] ticks_reg   [2];
    logic [TICK_W-1:0] ticks_next  [2];
    logic              armed_reg   [2];
    logic              armed_next  [2];
    logic              lost_reg    [2];
    logic              lost_next   [2];
    logic              blink_reg   [2];
    logic              blink_next  [2];
    logic [HOLD_W-1:0] btimer_reg  [2];
    logic [HOLD_W-1:0] btimer_next [2];
    logic [BPM_W-1:0]  rate_reg    [2];
    logic [BPM_W-1:0]  rate_next   [2];

    // Sequencer working registers.
    logic              chan_reg, chan_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [BPM_W-1:0]  carry_reg, carry_next;
    logic [BPM_W-1:0]  seed_reg, seed_next;
    logic [2:0]        zero_reg, zero_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [SUM_W-1:0]  bsum_reg, bsum_next;
    logic [BPM_W-1:0]  mean_reg, mean_next;
    logic              divgo_reg, divgo_next;

    // Result register.
    logic              ov_reg, ov_next;
    logic [BPM_W-1:0]  o_rate_reg, o_chest_reg, o_hand_reg;
    logic              o_blink_reg, o_src_reg;
    logic              load_out;

    // RAM port.
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [BPM_W-1:0]  wdata, rdata;

    div_req_t dreq;
    div_rsp_t drsp;

    logic             accept;
    logic [BPM_W-1:0] clamped;
    logic [BPM_W:0]   lo_lim, hi_lim;
    logic [9:0]       slow_x;
    logic [19:0]      slow_prod;

    pihr_ram #(
        .WIDTH (BPM_W),
        .DEPTH (RAM_D)
    ) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pihr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Configuration writes are taken whenever they come.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ivl_reg <= IVL_W'(250);
            max_ivl_reg <= IVL_W'(1500);
            window_reg  <= WIN_W'(5);
            agree_reg   <= AGREE_W'(8);
            hold_reg    <= HOLD_W'(250);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_INTERVAL: min_ivl_reg <= cfg_data[IVL_W-1:0];
                CFG_MAX_INTERVAL: max_ivl_reg <= cfg_data[IVL_W-1:0];
                CFG_WINDOW:       window_reg  <= cfg_data[WIN_W-1:0];
                CFG_AGREE:        agree_reg   <= cfg_data[AGREE_W-1:0];
                CFG_BLINK_HOLD:   hold_reg    <= cfg_data[HOLD_W-1:0];
                default:          ;
            endcase
        end
    end

    // The divider quotient is saturated to a byte where it stands for a bpm.
    assign clamped = (drsp.quotient > 16'(BPM_SAT)) ? BPM_SAT : drsp.quotient[BPM_W-1:0];

    // Cluster bounds around the seed, one bit wider so they cannot wrap.
    assign lo_lim = {1'b0, seed_reg} - (BPM_W+1)'(window_reg);
    assign hi_lim = {1'b0, seed_reg} + (BPM_W+1)'(window_reg);

    // Slow start rate (700 + mean) / 11, taken as a reciprocal multiply.
    assign slow_x    = SLOW_BIAS + 10'(mean_reg);
    assign slow_prod = 20'(slow_x) * 20'(SLOW_RECIP);

    always_comb
    begin
        logic [TICK_W-1:0] iv;
        logic [BPM_W:0]    e9;
        logic              in_cl;
        logic [BPM_W-1:0]  r;

        state_next = state_reg;
        for (int c = 0; c < 2; c++)
        begin
            ticks_next[c]  = ticks_reg[c];
            armed_next[c]  = armed_reg[c];
            lost_next[c]   = lost_reg[c];
            blink_next[c]  = blink_reg[c];
            btimer_next[c] = btimer_reg[c];
            rate_next[c]   = rate_reg[c];
        end
        chan_next  = chan_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        clr_next   = clr_reg;
        carry_next = carry_reg;
        seed_next  = seed_reg;
        zero_next  = zero_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        bcnt_next  = bcnt_reg;
        bsum_next  = bsum_reg;
        mean_next  = mean_reg;
        divgo_next = 1'b0;
        we         = 1'b0;
        waddr      = {chan_reg, i_reg};
        wdata      = carry_reg;
        raddr      = {chan_reg, i_reg};
        dreq.start    = divgo_reg;
        dreq.dividend = BPM_DIVIDEND;
        dreq.divisor  = 16'(ticks_reg[chan_reg]);
        load_out   = 1'b0;
        iv         = ticks_reg[chan_reg];
        e9         = {1'b0, rdata};
        in_cl      = (e9 >= lo_lim) && (e9 <= hi_lim);
        r          = rate_reg[chan_reg];

        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(RAM_D - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESULT;
                    if (kind == KIND_TICK)
                    begin
                        for (int c = 0; c < 2; c++)
                        begin
                            if (ticks_reg[c] > TICK_W'(max_ivl_reg))
                            begin
                                if (!lost_reg[c])
                                begin
                                    rate_next[c] = '0;
                                    lost_next[c] = 1'b1;
                                end
                                armed_next[c] = 1'b0;
                                ticks_next[c] = '0;
                            end
                            else
                            begin
                                ticks_next[c] = ticks_reg[c] + TICK_W'(1);
                            end
                            if (blink_reg[c])
                            begin
                                btimer_next[c] = btimer_reg[c] + HOLD_W'(1);
                                if (btimer_reg[c] > hold_reg)
                                begin
                                    blink_next[c] = 1'b0;
                                end
                            end
                            else
                            begin
                                btimer_next[c] = '0;
                            end
                        end
                    end
                    else
                    begin
                        chan_next = channel;
                        if (!armed_reg[channel])
                        begin
                            armed_next[channel] = 1'b1;
                            ticks_next[channel] = '0;
                        end
                        else if (ticks_reg[channel] <= TICK_W'(min_ivl_reg))
                        begin
                            ticks_next[channel] = '0;
                        end
                        else
                        begin
                            // Clamp the interval now; the tick count is cleared
                            // once the division has used it.
                            if (ticks_reg[channel] > TICK_W'(max_ivl_reg))
                            begin
                                ticks_next[channel] = TICK_W'(max_ivl_reg);
                            end
                            divgo_next = 1'b1;
                            state_next = ST_DIVBPM;
                        end
                    end
                end
            end
            ST_DIVBPM:
            begin
                if (drsp.done)
                begin
                    carry_next = (iv == '0) ? BPM_SAT : clamped;
                    ticks_next[chan_reg] = '0;
                    blink_next[chan_reg] = 1'b1;
                    lost_next[chan_reg]  = 1'b0;
                    i_next     = '0;
                    zero_next  = '0;
                    state_next = ST_SHRD;
                end
            end
            ST_SHRD:
            begin
                // Read entry i; the carried value is written there next.
                state_next = ST_SHWR;
            end
            ST_SHWR:
            begin
                we         = 1'b1;
                carry_next = rdata;
                if (i_reg < IDX_W'(3))
                begin
                    zero_next[i_reg[1:0]] = (carry_reg == '0);
                end
                if (i_reg == LAST_IDX)
                begin
                    state_next = ST_HEAD;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_SHRD;
                end
            end
            ST_HEAD:
            begin
                bcnt_next = '0;
                bsum_next = '0;
                i_next    = '0;
                if (&zero_reg)
                begin
                    rate_next[chan_reg] = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SEEDRD;
                end
            end
            ST_SEEDRD:
            begin
                raddr      = {chan_reg, i_reg};
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                seed_next = rdata;
                j_next    = '0;
                cnt_next  = '0;
                sum_next  = '0;
                if (rdata >= SEED_MIN)
                begin
                    raddr      = {chan_reg, IDX_W'(0)};
                    state_next = ST_SCAN;
                end
                else if (i_reg == LAST_IDX)
                begin
                    state_next = ST_MEAN;
                    divgo_next = 1'b1;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_SEEDRD;
                end
            end
            ST_SCAN:
            begin
                // Entry j is on the read port; j+1 is addressed for next cycle.
                raddr = {chan_reg, j_reg + IDX_W'(1)};
                if (in_cl)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    sum_next = sum_reg + SUM_W'(rdata);
                end
                if (j_reg == LAST_IDX)
                begin
                    if (in_cl ? (cnt_reg + CNT_W'(1) > bcnt_reg) : (cnt_reg > bcnt_reg))
                    begin
                        bcnt_next = in_cl ? cnt_reg + CNT_W'(1) : cnt_reg;
                        bsum_next = in_cl ? sum_reg + SUM_W'(rdata) : sum_reg;
                    end
                    if (i_reg == LAST_IDX)
                    begin
                        state_next = ST_MEAN;
                        divgo_next = 1'b1;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_SEEDRD;
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_MEAN:
            begin
                // Mean of the best cluster; an empty cluster gives zero at once.
                dreq.dividend = 16'(bsum_reg);
                dreq.divisor  = 16'(bcnt_reg);
                if (bcnt_reg == '0)
                begin
                    mean_next  = '0;
                    state_next = ST_DECIDE;
                end
                else if (drsp.done)
                begin
                    mean_next  = drsp.quotient[BPM_W-1:0];
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (CMP_W'(bcnt_reg) > CMP_W'(agree_reg))
                begin
                    rate_next[chan_reg] = mean_reg;
                    state_next = ST_RESULT;
                end
                else if (r > SEED_MIN)
                begin
                    if (mean_reg > r)
                    begin
                        rate_next[chan_reg] = r + BPM_W'(1);
                    end
                    else if (mean_reg < r)
                    begin
                        rate_next[chan_reg] = r - BPM_W'(1);
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SLOW;
                end
            end
            ST_SLOW:
            begin
                rate_next[chan_reg] = BPM_W'(slow_prod[19:SLOW_SHIFT]);
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                load_out   = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result waits in the output register until the receiver takes it.
    always_comb
    begin
        ov_next = ov_reg;
        if (out_valid && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            divgo_reg <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                ticks_reg[c]  <= '0;
                armed_reg[c]  <= 1'b0;
                lost_reg[c]   <= 1'b1;
                blink_reg[c]  <= 1'b0;
                btimer_reg[c] <= '0;
                rate_reg[c]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            divgo_reg <= divgo_next;
            for (int c = 0; c < 2; c++)
            begin
                ticks_reg[c]  <= ticks_next[c];
                armed_reg[c]  <= armed_next[c];
                lost_reg[c]   <= lost_next[c];
                blink_reg[c]  <= blink_next[c];
                btimer_reg[c] <= btimer_next[c];
                rate_reg[c]   <= rate_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg  <= chan_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        carry_reg <= carry_next;
        seed_reg  <= seed_next;
        zero_reg  <= zero_next;
        cnt_reg   <= cnt_next;
        sum_reg   <= sum_next;
        bcnt_reg  <= bcnt_next;
        bsum_reg  <= bsum_next;
        mean_reg  <= mean_next;
        if (load_out)
        begin
            o_chest_reg <= rate_reg[0];
            o_hand_reg  <= rate_reg[1];
            o_rate_reg  <= (rate_reg[0] != '0) ? rate_reg[0] : rate_reg[1];
            o_blink_reg <= lost_reg[0] ? blink_reg[1] : blink_reg[0];
            o_src_reg   <= lost_reg[0];
        end
    end

    assign out_valid   = ov_reg;
    assign heart_rate  = o_rate_reg;
    assign beat_blink  = o_blink_reg;
    assign rate_source = o_src_reg;
    assign chest_bpm   = o_chest_reg;
    assign hand_bpm    = o_hand_reg;

endmodule

/* sv/pihr_checker.sv */
module pihr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] heart_rate,
    input logic [7:0] chest_bpm,
    input logic [7:0] hand_bpm,
    input logic       rate_source
);

    // The combined rate is the chest rate when that is nonzero.
    a_rate_pick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heart_rate == ((chest_bpm != 8'd0) ? chest_bpm : hand_bpm)))
        else $error("heart_rate does not follow the channel rates");

    // A lost chest strap always reports a zero chest rate.
    a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rate_source) |-> (chest_bpm == 8'd0))
        else $error("chest lost but chest rate nonzero");

    // One item in flight: no acceptance in the cycle after one.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted back to back");

    // A held result stays put until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(heart_rate)))
        else $error("result changed while stalled");

endmodule

bind pulse_interval_heart_rate pihr_checker u_pihr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .heart_rate  (heart_rate),
    .chest_bpm   (chest_bpm),
    .hand_bpm    (hand_bpm),
    .rate_source (rate_source)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the two-channel heart rate block.
// Every accepted input item is run through a behavioural model of both
// channels, which produces the one result item that the block must return.
// A checker compares each accepted result item, field by field, with the
// oldest outstanding expectation.
module tb_top;
    import pihr_pkg::*;

    localparam int unsigned DEPTH      = 20;
    localparam int unsigned CYCLE_CAP  = 3000000;
    localparam int unsigned SETTLE     = 40;

    typedef struct packed {
        logic [BPM_W-1:0] heart_rate;
        logic             beat_blink;
        logic             rate_source;
        logic [BPM_W-1:0] chest_bpm;
        logic [BPM_W-1:0] hand_bpm;
    } hr_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = KIND_TICK;
    logic                  channel = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BPM_W-1:0]      heart_rate;
    logic                  beat_blink;
    logic                  rate_source;
    logic [BPM_W-1:0]      chest_bpm;
    logic [BPM_W-1:0]      hand_bpm;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Model copy of the registers and of each channel (index 0 chest, 1 hand).
    int unsigned      min_ivl, max_ivl, window, agree, hold;
    logic [TICK_W-1:0] ticks  [2];
    logic              armed  [2];
    logic              lost   [2];
    logic              blink  [2];
    logic [HOLD_W-1:0] btimer [2];
    logic [BPM_W-1:0]  rate   [2];
    logic [BPM_W-1:0]  hist   [2][DEPTH];

    hr_result_t  pending_results[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    pulse_interval_heart_rate #(.HISTORY_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .channel(channel),
        .out_valid(out_valid), .out_ready(out_ready),
        .heart_rate(heart_rate), .beat_blink(beat_blink), .rate_source(rate_source),
        .chest_bpm(chest_bpm), .hand_bpm(hand_bpm),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // The run is bounded by a plain cycle count.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[pulse_interval_heart_rate] ERROR");
            $finish;
        end
    end

    // The receiver stalls at random at the rate set by the current phase.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Rate from a history: the largest cluster of agreeing entries wins,
    // with the first one found taking a tie.
    function automatic logic [BPM_W-1:0] rate_from_history(input int ch,
                                                           input logic [BPM_W-1:0] old);
        int unsigned best_cnt, best_sum, cnt, sum, v, e, mean, r;
        best_cnt = 0;
        best_sum = 0;
        if (hist[ch][0] == 0 && hist[ch][1] == 0 && hist[ch][2] == 0)
            return '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            v = hist[ch][i];
            if (v < SEED_MIN)
                continue;
            cnt = 0;
            sum = 0;
            for (int j = 0; j < DEPTH; j++)
            begin
                e = hist[ch][j];
                if (e <= v + window && e + window >= v)
                begin
                    cnt++;
                    sum += e;
                end
            end
            if (cnt > best_cnt)
            begin
                best_cnt = cnt;
                best_sum = sum;
            end
        end
        mean = best_cnt != 0 ? (best_sum / best_cnt) & 8'hFF : 0;
        r = old;
        if (best_cnt > agree)
            r = mean;
        else if (r > SEED_MIN)
        begin
            if (mean > r)
                r++;
            else if (mean < r)
                r--;
        end
        else
            r = (SLOW_BIAS + mean) / SLOW_DIV;
        return r[BPM_W-1:0];
    endfunction

    // Applies one item to the channel model and returns the result it causes.
    function automatic hr_result_t apply_item(input logic k, input logic c);
        hr_result_t res;
        int unsigned iv, bpm, old_t;
        int ch;
        if (k == KIND_TICK)
        begin
            for (ch = 0; ch < 2; ch++)
            begin
                if (ticks[ch] > max_ivl)
                begin
                    if (!lost[ch])
                    begin
                        rate[ch] = '0;
                        lost[ch] = 1'b1;
                    end
                    armed[ch] = 1'b0;
                    ticks[ch] = '0;
                end
                else
                    ticks[ch] = ticks[ch] + 1'b1;
                if (blink[ch])
                begin
                    old_t = btimer[ch];
                    btimer[ch] = btimer[ch] + 1'b1;
                    if (old_t > hold)
                        blink[ch] = 1'b0;
                end
                else
                    btimer[ch] = '0;
            end
        end
        else
        begin
            ch = c;
            if (armed[ch])
            begin
                if (ticks[ch] > min_ivl)
                begin
                    iv = ticks[ch] > max_ivl ? max_ivl : ticks[ch];
                    bpm = iv != 0 ? BPM_DIVIDEND / iv : BPM_SAT;
                    if (bpm > BPM_SAT)
                        bpm = BPM_SAT;
                    for (int i = DEPTH - 1; i > 0; i--)
                        hist[ch][i] = hist[ch][i-1];
                    hist[ch][0] = bpm[BPM_W-1:0];
                    blink[ch] = 1'b1;
                    lost[ch] = 1'b0;
                    rate[ch] = rate_from_history(ch, rate[ch]);
                end
            end
            else
                armed[ch] = 1'b1;
            ticks[ch] = '0;
        end
        res.heart_rate  = rate[0] != 0 ? rate[0] : rate[1];
        res.beat_blink  = !lost[0] ? blink[0] : blink[1];
        res.rate_source = lost[0];
        res.chest_bpm   = rate[0];
        res.hand_bpm    = rate[1];
        return res;
    endfunction

    // Result checker: each accepted result item against the oldest expectation.
    always @(posedge clk)
    begin
        hr_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected (heart_rate %0d)",
                         $time, heart_rate);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (heart_rate !== want.heart_rate)
                begin
                    $display("%0t: heart_rate expected %0d actual %0d",
                             $time, want.heart_rate, heart_rate);
                    errors++;
                end
                if (beat_blink !== want.beat_blink)
                begin
                    $display("%0t: beat_blink expected %0d actual %0d",
                             $time, want.beat_blink, beat_blink);
                    errors++;
                end
                if (rate_source !== want.rate_source)
                begin
                    $display("%0t: rate_source expected %0d actual %0d",
                             $time, want.rate_source, rate_source);
                    errors++;
                end
                if (chest_bpm !== want.chest_bpm)
                begin
                    $display("%0t: chest_bpm expected %0d actual %0d",
                             $time, want.chest_bpm, chest_bpm);
                    errors++;
                end
                if (hand_bpm !== want.hand_bpm)
                begin
                    $display("%0t: hand_bpm expected %0d actual %0d",
                             $time, want.hand_bpm, hand_bpm);
                    errors++;
                end
            end
        end
    end

    // Sends one item. It is entered at a rising edge; valid is only lowered
    // when the sender decides to idle, so back-to-back items keep it high.
    task automatic send_item(input logic k, input logic c);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        kind     <= k;
        channel  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_item(k, c));
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n)
            send_item(KIND_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Waits with the input idle until every expected result item has come.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // Register write; the block is brought to rest first.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] d;
        d = val[CFG_DATA_W-1:0];
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MIN_INTERVAL: min_ivl = d;
            CFG_MAX_INTERVAL: max_ivl = d;
            CFG_WINDOW:       window  = d[WIN_W-1:0];
            CFG_AGREE:        agree   = d[AGREE_W-1:0];
            CFG_BLINK_HOLD:   hold    = d[HOLD_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic write_all(input int unsigned mn, mx, win, agr, hld);
        write_reg(CFG_MIN_INTERVAL, mn);
        write_reg(CFG_MAX_INTERVAL, mx);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_AGREE, agr);
        write_reg(CFG_BLINK_HOLD, hld);
    endtask

    // Reset register values: arming, then one beat at a realistic interval,
    // so the bpm comes from a real division and the slow start path is taken.
    task automatic test_reset_values();
        send_ticks(2);
        send_item(KIND_BEAT, 1'b0);
        send_ticks($urandom_range(251, 275));
        send_item(KIND_BEAT, 1'b0);
        send_item(KIND_BEAT, 1'b1);
    endtask

    // Short intervals: arming, saturated bpm, a short beat, loss on both sides.
    task automatic test_short_intervals();
        write_all(2, 6, 0, 0, 0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_BEAT, 1'b0);
        send_item(KIND_BEAT, 1'b1);
        send_ticks(3);
        send_item(KIND_BEAT, 1'b0);
        send_item(KIND_BEAT, 1'b0);
        send_ticks(3);
        send_item(KIND_BEAT, 1'b1);
        send_ticks(9);
        send_item(KIND_BEAT, 1'b1);
    endtask

    // A maximum of zero clamps every interval to zero, so the bpm saturates.
    // An index past the last register must change nothing.
    task automatic test_zero_interval();
        write_all(0, 0, 31, 20, 255);
        write_reg(3'd5, 11'h7FF);
        write_reg(3'd7, 11'h000);
        send_item(KIND_BEAT, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_BEAT, 1'b0);
        send_item(KIND_BEAT, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_BEAT, 1'b1);
        send_ticks(4);
    endtask

    // Both interval registers at their top: every beat this soon is too short.
    task automatic test_long_interval();
        write_all(2047, 2047, 5, 8, 250);
        send_item(KIND_BEAT, 1'b1);
        send_ticks(3);
        send_item(KIND_BEAT, 1'b1);
        send_ticks(2);
    endtask

    // Random phase: mostly well-formed beat trains at a random interval,
    // with some short beats, losses and noise items among them.
    task automatic test_random_phase(input int unsigned idle, stall, trains);
        int unsigned pick, n, mn, mx;
        send_idle_pct = idle;
        stall_pct     = stall;
        mn = $urandom_range(1, 6);
        mx = mn + $urandom_range(1, 8);
        write_all(mn, mx, $urandom_range(0, 31), $urandom_range(0, 20),
                  $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 254));
        repeat (trains)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n = $urandom_range(mn + 1, mx + 2);
            else if (pick < 85)
                n = $urandom_range(0, mn);
            else
                n = mx + $urandom_range(2, 5);
            send_ticks(n);
            send_item(KIND_BEAT, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 4))
                send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        // Hold the sender off once the train ends, so the block empties fully.
        wait_idle();
        send_ticks($urandom_range(1, 20));
    endtask

    initial
    begin
        min_ivl = 250;
        max_ivl = 1500;
        window  = 5;
        agree   = 8;
        hold    = 250;
        for (int ch = 0; ch < 2; ch++)
        begin
            ticks[ch]  = '0;
            armed[ch]  = 1'b0;
            lost[ch]   = 1'b1;
            blink[ch]  = 1'b0;
            btimer[ch] = '0;
            rate[ch]   = '0;
            for (int i = 0; i < DEPTH; i++)
                hist[ch][i] = '0;
        end
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_short_intervals();
        test_zero_interval();
        test_long_interval();

        test_random_phase(0, 0, 5);
        test_random_phase(55, 0, 5);
        test_random_phase(0, 55, 5);
        test_random_phase(34, 34, 5);

        wait_idle();
        if (errors == 0)
            $display("[pulse_interval_heart_rate] OK");
        else
            $display("[pulse_interval_heart_rate] ERROR");
        $finish;
    end
endmodule
